[src/moke_pkg.sv]
// Shared types and constants of the monomial order key encoder.
package moke_pkg;

   // Fixed field layout of the request and result ports.
   localparam int NUM_IN = 8;
   localparam int EXP_W  = 16;
   localparam int DEG_W  = 8;
   localparam int WGT_W  = 8;
   localparam int KEY_W  = 32;
   localparam int P_W    = EXP_W + DEG_W;
   localparam int WP_W   = EXP_W + WGT_W + 1;
   localparam int S_W    = P_W + 4;
   localparam int CSR_W  = 64;
   localparam int IDX_W  = 3;

   typedef enum logic [2:0] {
      MODE_LEX     = 3'd0,
      MODE_RLEX    = 3'd1,
      MODE_GLEX    = 3'd2,
      MODE_GRLEX   = 3'd3,
      MODE_PRODUCT = 3'd4,
      MODE_ELIM    = 3'd5
   } mode_type;

   typedef enum logic [IDX_W-1:0] {
      CSR_ORDER_MODE    = 3'd0,
      CSR_VAR_COUNT     = 3'd1,
      CSR_DEGREE_VECTOR = 3'd2,
      CSR_BLOCK_ENDS    = 3'd3,
      CSR_ELIM_COUNT    = 3'd4,
      CSR_WEIGHT_VECTOR = 3'd5,
      CSR_WEIGHT_ENABLE = 3'd6
   } csr_index_type;

   localparam logic [2:0]       ORDER_MODE_RST = 3'd3;
   localparam logic [3:0]       VAR_COUNT_RST  = 4'd8;
   localparam logic [CSR_W-1:0] DEGREE_RST     = 64'h0101_0101_0101_0101;
   localparam logic [7:0]       BLOCK_ENDS_RST = 8'h80;
   localparam logic [3:0]       ELIM_COUNT_RST = 4'd1;

   // Effective ordering control, already cleaned up from the raw registers.
   typedef struct packed {
      mode_type   mode;
      logic [3:0] count;
      logic [3:0] elim;
   } ctl_type;

endpackage

[src/moke_key_route.sv]
// Routes the per-variable key values to their key positions for the active order.
module moke_key_route #(
   parameter int VARS = 8
) (
   input  moke_pkg::ctl_type              ctl,
   input  logic [VARS-1:0]                brk,
   input  logic signed [moke_pkg::KEY_W-1:0] val [VARS],
   output logic signed [moke_pkg::KEY_W-1:0] key [(VARS < moke_pkg::NUM_IN) ? VARS :
                                                  moke_pkg::NUM_IN]
);

   localparam int NK = (VARS < moke_pkg::NUM_IN) ? VARS : moke_pkg::NUM_IN;
   localparam int DW = $clog2(VARS + 1) + 1;

   logic [DW-1:0] start_of [VARS];
   logic [DW-1:0] end_of   [VARS];
   logic [DW-1:0] dest     [VARS];
   logic [DW-1:0] st;
   logic [DW-1:0] en;
   logic [DW-1:0] nn;
   logic [DW-1:0] kk;

   assign nn = DW'(ctl.count);
   assign kk = DW'(ctl.elim);

   // Block boundaries for the product order: each variable learns the first
   // and last index of the block that holds it.
   always_comb begin
      st = '0;
      for (int i = 0; i < VARS; i++) begin
         start_of[i] = st;
         if (brk[i]) begin
            st = DW'(i + 1);
         end
      end
      en = DW'(VARS - 1);
      for (int i = VARS - 1; i >= 0; i--) begin
         if (brk[i]) begin
            en = DW'(i);
         end
         end_of[i] = en;
      end
   end

   always_comb begin
      for (int i = 0; i < VARS; i++) begin
         unique case (ctl.mode) inside
            moke_pkg::MODE_LEX, moke_pkg::MODE_RLEX: begin
               dest[i] = DW'(i);
            end
            moke_pkg::MODE_GLEX: begin
               dest[i] = (DW'(i + 1) == nn) ? '0 : DW'(i + 1);
            end
            moke_pkg::MODE_PRODUCT: begin
               dest[i] = start_of[i] + end_of[i] - DW'(i);
            end
            moke_pkg::MODE_ELIM: begin
               if (DW'(i + 1) < kk) begin
                  dest[i] = nn - 1'b1 - DW'(i);
               end else if (DW'(i + 1) == kk) begin
                  dest[i] = '0;
               end else begin
                  dest[i] = nn - DW'(i);
               end
            end
            default: begin
               dest[i] = nn - 1'b1 - DW'(i);
            end
         endcase
      end
   end

   // The active variables map onto distinct positions, so an OR merge suffices.
   always_comb begin
      for (int r = 0; r < NK; r++) begin
         key[r] = '0;
         for (int i = 0; i < VARS; i++) begin
            if (DW'(i) < nn && dest[i] == DW'(r)) begin
               key[r] = key[r] | val[i];
            end
         end
      end
   end

endmodule

[src/monomial_order_key_encoder.sv]
// Top level of the monomial order key encoder: config registers and datapath.
// An accepted item passes through the input, product, sum and result registers
// before its result shows with rsp_valid high.
// Throughput: one item per cycle; busy stays low and results cannot be stalled.
// Reset (synchronous, active high) loads the register defaults and drops all
// items in flight; configuration writes complete in the cycle they are presented.
module monomial_order_key_encoder #(
   parameter int VARS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [15:0] req_exponent_0,
   input  logic [15:0] req_exponent_1,
   input  logic [15:0] req_exponent_2,
   input  logic [15:0] req_exponent_3,
   input  logic [15:0] req_exponent_4,
   input  logic [15:0] req_exponent_5,
   input  logic [15:0] req_exponent_6,
   input  logic [15:0] req_exponent_7,
   output logic        rsp_valid,
   output logic signed [31:0] rsp_weight_value,
   output logic signed [31:0] rsp_key_0,
   output logic signed [31:0] rsp_key_1,
   output logic signed [31:0] rsp_key_2,
   output logic signed [31:0] rsp_key_3,
   output logic signed [31:0] rsp_key_4,
   output logic signed [31:0] rsp_key_5,
   output logic signed [31:0] rsp_key_6,
   output logic signed [31:0] rsp_key_7,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   localparam int NW = $clog2(VARS + 1);
   localparam int NE = (VARS < moke_pkg::NUM_IN) ? VARS : moke_pkg::NUM_IN;
   localparam int NK = NE;

   // Configuration registers.
   logic [2:0]                  order_mode_ff;
   logic [3:0]                  var_count_ff;
   logic [moke_pkg::CSR_W-1:0]  degree_ff;
   logic [7:0]                  block_ends_ff;
   logic [3:0]                  elim_ff;
   logic [moke_pkg::CSR_W-1:0]  weight_ff;
   logic                        wen_ff;

   logic [NW-1:0]               n_cnt;
   moke_pkg::ctl_type           ctl;
   logic                        elim_ok;

   // Pipeline.
   logic [moke_pkg::EXP_W-1:0]         req_exp   [moke_pkg::NUM_IN];
   logic [moke_pkg::EXP_W-1:0]         exp_a_ff  [NE];
   logic [moke_pkg::P_W-1:0]           p_in      [VARS];
   logic [moke_pkg::P_W-1:0]           p_b_ff    [VARS];
   logic signed [moke_pkg::WP_W-1:0]   wp_in     [NE];
   logic signed [moke_pkg::WP_W-1:0]   wp_b_ff   [NE];
   logic [VARS-1:0]                    brk;
   logic [VARS+moke_pkg::NUM_IN-1:0]   ends_ext;
   logic [moke_pkg::S_W-1:0]           acc;
   logic                               first;
   logic [moke_pkg::S_W-1:0]           s_sum     [VARS];
   logic signed [moke_pkg::KEY_W-1:0]  val_in    [VARS];
   logic signed [moke_pkg::KEY_W-1:0]  val_c_ff  [VARS];
   logic signed [moke_pkg::KEY_W-1:0]  wsum_in;
   logic signed [moke_pkg::KEY_W-1:0]  wsum_c_ff;
   logic signed [moke_pkg::KEY_W-1:0]  key_route [NK];
   logic signed [moke_pkg::KEY_W-1:0]  key_d_ff  [NK];
   logic signed [moke_pkg::KEY_W-1:0]  wsum_d_ff;
   logic signed [moke_pkg::KEY_W-1:0]  key_out   [moke_pkg::NUM_IN];
   logic                               a_valid_ff;
   logic                               b_valid_ff;
   logic                               c_valid_ff;
   logic                               d_valid_ff;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         order_mode_ff <= moke_pkg::ORDER_MODE_RST;
         var_count_ff  <= moke_pkg::VAR_COUNT_RST;
         degree_ff     <= moke_pkg::DEGREE_RST;
         block_ends_ff <= moke_pkg::BLOCK_ENDS_RST;
         elim_ff       <= moke_pkg::ELIM_COUNT_RST;
         weight_ff     <= '0;
         wen_ff        <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            moke_pkg::CSR_ORDER_MODE:    order_mode_ff <= csr_wdata[2:0];
            moke_pkg::CSR_VAR_COUNT:     var_count_ff  <= csr_wdata[3:0];
            moke_pkg::CSR_DEGREE_VECTOR: degree_ff     <= csr_wdata;
            moke_pkg::CSR_BLOCK_ENDS:    block_ends_ff <= csr_wdata[7:0];
            moke_pkg::CSR_ELIM_COUNT:    elim_ff       <= csr_wdata[3:0];
            moke_pkg::CSR_WEIGHT_VECTOR: weight_ff     <= csr_wdata;
            moke_pkg::CSR_WEIGHT_ENABLE: wen_ff        <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // A variable count above the built width acts as the built width.
   assign n_cnt   = (var_count_ff > 4'(VARS)) ? NW'(VARS) : NW'(var_count_ff);
   assign elim_ok = (elim_ff >= 4'd1) && (elim_ff < 4'(n_cnt));

   always_comb begin
      ctl.count = 4'(n_cnt);
      ctl.elim  = elim_ff;
      unique case (order_mode_ff)
         moke_pkg::MODE_LEX:     ctl.mode = moke_pkg::MODE_LEX;
         moke_pkg::MODE_RLEX:    ctl.mode = moke_pkg::MODE_RLEX;
         moke_pkg::MODE_GLEX:    ctl.mode = moke_pkg::MODE_GLEX;
         moke_pkg::MODE_PRODUCT: ctl.mode = moke_pkg::MODE_PRODUCT;
         moke_pkg::MODE_ELIM:
            ctl.mode = elim_ok ? moke_pkg::MODE_ELIM : moke_pkg::MODE_GRLEX;
         default:                ctl.mode = moke_pkg::MODE_GRLEX;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= start && !busy;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
      end
   end

   assign req_exp[0] = req_exponent_0;
   assign req_exp[1] = req_exponent_1;
   assign req_exp[2] = req_exponent_2;
   assign req_exp[3] = req_exponent_3;
   assign req_exp[4] = req_exponent_4;
   assign req_exp[5] = req_exponent_5;
   assign req_exp[6] = req_exponent_6;
   assign req_exp[7] = req_exponent_7;

   // Input register: exponents of unused variables are forced to zero here.
   always_ff @(posedge clock) begin
      if (start && !busy) begin
         for (int i = 0; i < NE; i++) begin
            exp_a_ff[i] <= (i < int'(n_cnt)) ? req_exp[i] : '0;
         end
      end
   end

   // Product stage. Lex and rlex carry the bare exponent instead of the product.
   for (genvar g = 0; g < VARS; g++) begin : g_var
      if (g < NE) begin : g_live
         logic [moke_pkg::DEG_W-1:0] deg;
         assign deg = degree_ff[moke_pkg::DEG_W*g +: moke_pkg::DEG_W];
         assign p_in[g] = (ctl.mode == moke_pkg::MODE_LEX || ctl.mode == moke_pkg::MODE_RLEX)
                          ? moke_pkg::P_W'(exp_a_ff[g])
                          : moke_pkg::P_W'(deg) * moke_pkg::P_W'(exp_a_ff[g]);
         assign wp_in[g] = $signed(weight_ff[moke_pkg::WGT_W*g +: moke_pkg::WGT_W])
                           * $signed({1'b0, exp_a_ff[g]});
      end else begin : g_none
         assign p_in[g] = '0;
      end
   end

   always_ff @(posedge clock) begin
      p_b_ff  <= p_in;
      wp_b_ff <= wp_in;
   end

   // Segment ends: the last used variable always closes a segment; product
   // blocks and the elimination split add their own.
   assign ends_ext = {{VARS{1'b0}}, block_ends_ff};

   always_comb begin
      for (int i = 0; i < VARS; i++) begin
         brk[i] = (i == int'(n_cnt) - 1)
                  || (ctl.mode == moke_pkg::MODE_ELIM && i == int'(ctl.elim) - 1)
                  || (ctl.mode == moke_pkg::MODE_PRODUCT && ends_ext[i]);
      end
   end

   always_comb begin
      first = 1'b1;
      acc   = '0;
      for (int i = 0; i < VARS; i++) begin
         acc      = first ? moke_pkg::S_W'(p_b_ff[i]) : acc + moke_pkg::S_W'(p_b_ff[i]);
         s_sum[i] = acc;
         first    = brk[i];
      end
      for (int i = 0; i < VARS; i++) begin
         case (ctl.mode) inside
            moke_pkg::MODE_LEX:  val_in[i] = $signed({8'b0, p_b_ff[i]});
            moke_pkg::MODE_RLEX: val_in[i] = -$signed({8'b0, p_b_ff[i]});
            moke_pkg::MODE_GLEX: begin
               // The last used variable carries the total degree to key 0.
               val_in[i] = (i == int'(n_cnt) - 1) ? $signed({4'b0, s_sum[i]})
                                                  : $signed({8'b0, p_b_ff[i]});
            end
            default:             val_in[i] = $signed({4'b0, s_sum[i]});
         endcase
      end
      wsum_in = '0;
      for (int i = 0; i < NE; i++) begin
         wsum_in = wsum_in + moke_pkg::KEY_W'(wp_b_ff[i]);
      end
      if (!wen_ff) begin
         wsum_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      val_c_ff  <= val_in;
      wsum_c_ff <= wsum_in;
   end

   moke_key_route #(
      .VARS (VARS)
   ) u_route (
      .ctl (ctl),
      .brk (brk),
      .val (val_c_ff),
      .key (key_route)
   );

   always_ff @(posedge clock) begin
      key_d_ff  <= key_route;
      wsum_d_ff <= wsum_c_ff;
   end

   for (genvar g = 0; g < moke_pkg::NUM_IN; g++) begin : g_key
      if (g < NK) begin : g_used
         assign key_out[g] = key_d_ff[g];
      end else begin : g_zero
         assign key_out[g] = '0;
      end
   end

   assign rsp_valid        = d_valid_ff;
   assign rsp_weight_value = wsum_d_ff;
   assign rsp_key_0        = key_out[0];
   assign rsp_key_1        = key_out[1];
   assign rsp_key_2        = key_out[2];
   assign rsp_key_3        = key_out[3];
   assign rsp_key_4        = key_out[4];
   assign rsp_key_5        = key_out[5];
   assign rsp_key_6        = key_out[6];
   assign rsp_key_7        = key_out[7];

endmodule

[src/moke_checker.sv]
// Port-level checker for the monomial order key encoder, bound to the top level.
module moke_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic signed [31:0] rsp_weight_value,
   input logic        csr_valid,
   input logic        csr_ready,
   input logic [2:0]  csr_index,
   input logic [63:0] csr_wdata
);

   logic wen_ff;

   // Shadow of the weight enable register, followed from config transfers.
   always_ff @(posedge clock) begin
      if (reset) begin
         wen_ff <= 1'b0;
      end else if (csr_valid && csr_ready && csr_index == moke_pkg::CSR_WEIGHT_ENABLE) begin
         wen_ff <= csr_wdata[0];
      end
   end

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##4 rsp_valid)
      else $error("accepted item did not produce a result after four cycles");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 4))
      else $error("result strobe without a matching accepted item");

   a_weight_off: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !wen_ff) |-> (rsp_weight_value == 32'sd0))
      else $error("weight value nonzero while the weight row is disabled");

endmodule

bind monomial_order_key_encoder moke_checker u_moke_checker (.*);

[tb/tb_monomial_order_key_encoder.sv]
// Self-checking testbench for the monomial order key encoder.
module tb_monomial_order_key_encoder;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RESULT_LATENCY  = 4;
   localparam int SETTLE_CYCLES   = RESULT_LATENCY + 2;
   localparam int END_CYCLES      = 4 * RESULT_LATENCY;
   localparam int PHASES          = 12;
   localparam int ITEMS_PER_PHASE = 75;
   localparam int CYCLE_LIMIT     = 200000;
   localparam int MAX_REPORTS     = 40;

   // Register index with no register behind it; writes there must be dropped.
   localparam logic [2:0] CSR_NO_REGISTER = 3'd7;
   // Order mode code outside the defined set; it falls back to grlex.
   localparam logic [2:0] MODE_UNDEFINED = 3'd7;

   localparam logic [7:0][15:0] EXP_ZERO     = '0;
   localparam logic [7:0][15:0] EXP_FULL     = {8{16'hFFFF}};
   localparam logic [7:0][15:0] EXP_RAMP     = {16'd800, 16'd700, 16'd600, 16'd500,
                                                16'd400, 16'd300, 16'd200, 16'd100};
   localparam logic [7:0][15:0] EXP_CHECKER  = {4{16'hAAAA, 16'h5555}};
   localparam logic [7:0][15:0] EXP_MIXED    = {16'hFFFF, 16'h0000, 16'h8001, 16'h7FFE,
                                                16'h0001, 16'hFFFE, 16'h1234, 16'hEDCB};

   typedef struct packed {
      logic [31:0]      weight_value;
      logic [7:0][31:0] key;
   } key_result_type;

   typedef struct packed {
      logic             is_write;
      logic [2:0]       index;
      logic [63:0]      data;
      logic [7:0][15:0] exps;
      logic             has_key;
      key_result_type   key;
   } script_row_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [15:0] req_exponent_0 = '0;
   logic [15:0] req_exponent_1 = '0;
   logic [15:0] req_exponent_2 = '0;
   logic [15:0] req_exponent_3 = '0;
   logic [15:0] req_exponent_4 = '0;
   logic [15:0] req_exponent_5 = '0;
   logic [15:0] req_exponent_6 = '0;
   logic [15:0] req_exponent_7 = '0;
   logic        rsp_valid;
   logic signed [31:0] rsp_weight_value;
   logic signed [31:0] rsp_key_0, rsp_key_1, rsp_key_2, rsp_key_3;
   logic signed [31:0] rsp_key_4, rsp_key_5, rsp_key_6, rsp_key_7;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [63:0] csr_wdata = '0;

   logic [7:0][31:0] observed_keys;
   assign observed_keys = {rsp_key_7, rsp_key_6, rsp_key_5, rsp_key_4,
                           rsp_key_3, rsp_key_2, rsp_key_1, rsp_key_0};

   // Register shadow used by the key predictor.
   logic [2:0]  cfg_mode;
   logic [3:0]  cfg_count;
   logic [63:0] cfg_degrees;
   logic [7:0]  cfg_block_ends;
   logic [3:0]  cfg_elim;
   logic [63:0] cfg_weights;
   logic        cfg_weight_en;

   key_result_type expected_keys[$];
   script_row_type script[$];
   int          mismatch_count = 0;
   int          results_checked = 0;
   int          items_sent = 0;
   int          settings_used = 0;
   int          cycle_count = 0;

   monomial_order_key_encoder u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_exponent_0   (req_exponent_0),
      .req_exponent_1   (req_exponent_1),
      .req_exponent_2   (req_exponent_2),
      .req_exponent_3   (req_exponent_3),
      .req_exponent_4   (req_exponent_4),
      .req_exponent_5   (req_exponent_5),
      .req_exponent_6   (req_exponent_6),
      .req_exponent_7   (req_exponent_7),
      .rsp_valid        (rsp_valid),
      .rsp_weight_value (rsp_weight_value),
      .rsp_key_0        (rsp_key_0),
      .rsp_key_1        (rsp_key_1),
      .rsp_key_2        (rsp_key_2),
      .rsp_key_3        (rsp_key_3),
      .rsp_key_4        (rsp_key_4),
      .rsp_key_5        (rsp_key_5),
      .rsp_key_6        (rsp_key_6),
      .rsp_key_7        (rsp_key_7),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d results outstanding",
                  $time, cycle_count, expected_keys.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   // Computes the key and weighted degree for one exponent vector.
   function automatic key_result_type encode_key(input logic [7:0][15:0] exps);
      key_result_type result;
      longint      e[8];
      longint      p[8];
      longint      key[8];
      longint      w;
      longint      wsum;
      longint      sum;
      logic [7:0]  ends;
      logic        prefix_order;
      int          n, k, i, j, first;
      n = (cfg_count > 8) ? 8 : int'(cfg_count);
      k = int'(cfg_elim);
      wsum = 0;
      for (i = 0; i < 8; i++) begin
         e[i] = (i < n) ? longint'(exps[i]) : 0;
         p[i] = longint'(cfg_degrees[8*i +: 8]) * e[i];
         w = $signed(cfg_weights[8*i +: 8]);
         wsum += w * e[i];
         key[i] = 0;
      end
      prefix_order = 1'b0;
      ends = '0;
      case (cfg_mode)
         moke_pkg::MODE_LEX: begin
            for (i = 0; i < n; i++) key[i] = e[i];
         end
         moke_pkg::MODE_RLEX: begin
            for (i = 0; i < n; i++) key[i] = -e[i];
         end
         moke_pkg::MODE_GLEX: begin
            for (i = 0; i < n; i++) begin
               key[0] += p[i];
               if (i + 1 < n) key[i + 1] = p[i];
            end
         end
         moke_pkg::MODE_PRODUCT: begin
            prefix_order = 1'b1;
            ends = cfg_block_ends;
         end
         moke_pkg::MODE_ELIM: begin
            if (k >= 1 && k < n) begin
               sum = 0;
               for (i = 0; i + 1 < k; i++) begin
                  sum += p[i];
                  key[n - 1 - i] = sum;
               end
               key[0] = sum + p[k - 1];
               sum = 0;
               for (i = k; i < n; i++) begin
                  sum += p[i];
                  key[n - i] = sum;
               end
            end else begin
               prefix_order = 1'b1;
            end
         end
         default: begin
            prefix_order = 1'b1;
         end
      endcase
      // Graded reverse order, restarted at every block end; the last variable
      // always closes a block.
      if (prefix_order) begin
         first = 0;
         for (i = 0; i < n; i++) begin
            if (i + 1 == n || ends[i]) begin
               sum = 0;
               for (j = first; j <= i; j++) begin
                  sum += p[j];
                  key[first + i - j] = sum;
               end
               first = i + 1;
            end
         end
      end
      result.weight_value = cfg_weight_en ? wsum[31:0] : 32'd0;
      for (i = 0; i < 8; i++) result.key[i] = key[i][31:0];
      return result;
   endfunction

   function automatic script_row_type csr_row(input logic [2:0] index,
                                              input logic [63:0] data);
      script_row_type row;
      row = '0;
      row.is_write = 1'b1;
      row.index = index;
      row.data = data;
      return row;
   endfunction

   function automatic script_row_type item_row(input logic [7:0][15:0] exps);
      script_row_type row;
      row = '0;
      row.exps = exps;
      return row;
   endfunction

   // Row whose keys are typed in; the weight row is disabled wherever this is used.
   function automatic script_row_type known_row(input logic [7:0][15:0] exps,
                                                input logic [7:0][31:0] keys);
      script_row_type row;
      row = item_row(exps);
      row.has_key = 1'b1;
      row.key.weight_value = '0;
      row.key.key = keys;
      return row;
   endfunction

   function automatic logic [7:0][15:0] random_exponents();
      logic [7:0][15:0] exps;
      int               i;
      for (i = 0; i < 8; i++) begin
         case ($urandom_range(9))
            0: exps[i] = 16'h0000;
            1: exps[i] = 16'hFFFF;
            2, 3: exps[i] = 16'($urandom_range(15));
            default: exps[i] = 16'($urandom_range(65535));
         endcase
      end
      return exps;
   endfunction

   function automatic logic [7:0] random_byte_extreme(input logic [7:0] low,
                                                      input logic [7:0] high);
      case ($urandom_range(5))
         0: return low;
         1: return high;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   task automatic shadow_write(input logic [2:0] index, input logic [63:0] data);
      case (index)
         moke_pkg::CSR_ORDER_MODE:    cfg_mode = data[2:0];
         moke_pkg::CSR_VAR_COUNT:     cfg_count = data[3:0];
         moke_pkg::CSR_DEGREE_VECTOR: cfg_degrees = data;
         moke_pkg::CSR_BLOCK_ENDS:    cfg_block_ends = data[7:0];
         moke_pkg::CSR_ELIM_COUNT:    cfg_elim = data[3:0];
         moke_pkg::CSR_WEIGHT_VECTOR: cfg_weights = data;
         moke_pkg::CSR_WEIGHT_ENABLE: cfg_weight_en = data[0];
         default: ;
      endcase
   endtask

   // Leaves csr_valid high so that writes can follow back to back.
   task automatic write_csr(input logic [2:0] index, input logic [63:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      shadow_write(index, data);
   endtask

   task automatic close_csr();
      csr_valid <= 1'b0;
   endtask

   // Brings the block to idle so that registers may change.
   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (expected_keys.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Leaves start high; the caller lowers it when the sender goes idle.
   task automatic send_item(input logic [7:0][15:0] exps, input logic has_key,
                            input key_result_type key);
      req_exponent_0 <= exps[0];
      req_exponent_1 <= exps[1];
      req_exponent_2 <= exps[2];
      req_exponent_3 <= exps[3];
      req_exponent_4 <= exps[4];
      req_exponent_5 <= exps[5];
      req_exponent_6 <= exps[6];
      req_exponent_7 <= exps[7];
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_keys.push_back(has_key ? key : encode_key(exps));
      items_sent++;
   endtask

   task automatic randomize_settings();
      logic [63:0] data;
      int          i;
      data = {$urandom, $urandom};
      data[2:0] = 3'($urandom_range(7));
      write_csr(moke_pkg::CSR_ORDER_MODE, data);
      data = {$urandom, $urandom};
      case ($urandom_range(9))
         8: data[3:0] = 4'd0;
         9: data[3:0] = 4'($urandom_range(15, 9));
         default: data[3:0] = 4'($urandom_range(8, 1));
      endcase
      write_csr(moke_pkg::CSR_VAR_COUNT, data);
      for (i = 0; i < 8; i++) data[8*i +: 8] = random_byte_extreme(8'h00, 8'hFF);
      write_csr(moke_pkg::CSR_DEGREE_VECTOR, data);
      data = {$urandom, $urandom};
      write_csr(moke_pkg::CSR_BLOCK_ENDS, data);
      data = {$urandom, $urandom};
      data[3:0] = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(7, 1));
      write_csr(moke_pkg::CSR_ELIM_COUNT, data);
      for (i = 0; i < 8; i++) data[8*i +: 8] = random_byte_extreme(8'h80, 8'h7F);
      write_csr(moke_pkg::CSR_WEIGHT_VECTOR, data);
      data = {$urandom, $urandom};
      write_csr(moke_pkg::CSR_WEIGHT_ENABLE, data);
      close_csr();
      settings_used++;
   endtask

   task automatic build_script();
      // Reset settings: grlex over eight variables of degree one.
      script.push_back(known_row(EXP_ZERO, '0));
      script.push_back(known_row(EXP_FULL, {32'd65535, 32'd131070, 32'd196605, 32'd262140,
                                            32'd327675, 32'd393210, 32'd458745, 32'd524280}));
      script.push_back(item_row(EXP_RAMP));
      script.push_back(item_row(EXP_CHECKER));
      // Upper bits of a narrow register are dropped.
      script.push_back(csr_row(moke_pkg::CSR_ORDER_MODE, {{61{1'b1}}, moke_pkg::MODE_LEX}));
      script.push_back(known_row(EXP_FULL, {8{32'd65535}}));
      script.push_back(csr_row(moke_pkg::CSR_ORDER_MODE, 64'(moke_pkg::MODE_RLEX)));
      script.push_back(known_row(EXP_FULL, {8{-32'sd65535}}));
      // A write to the unused index must leave every register alone.
      script.push_back(csr_row(CSR_NO_REGISTER, '1));
      script.push_back(item_row(~EXP_CHECKER));
      script.push_back(csr_row(moke_pkg::CSR_DEGREE_VECTOR, '1));
      script.push_back(csr_row(moke_pkg::CSR_WEIGHT_VECTOR, 64'h807F_807F_807F_807F));
      script.push_back(csr_row(moke_pkg::CSR_WEIGHT_ENABLE, 64'd1));
      script.push_back(csr_row(moke_pkg::CSR_ORDER_MODE, 64'(moke_pkg::MODE_GLEX)));
      script.push_back(item_row(EXP_FULL));
      script.push_back(item_row(EXP_MIXED));
      script.push_back(csr_row(moke_pkg::CSR_WEIGHT_ENABLE, 64'd0));
      script.push_back(csr_row(moke_pkg::CSR_VAR_COUNT, 64'd0));
      script.push_back(known_row(EXP_FULL, '0));
      script.push_back(csr_row(moke_pkg::CSR_WEIGHT_ENABLE, 64'd1));
      script.push_back(csr_row(moke_pkg::CSR_VAR_COUNT, 64'd15));
      script.push_back(csr_row(moke_pkg::CSR_ORDER_MODE, 64'(MODE_UNDEFINED)));
      script.push_back(item_row(EXP_RAMP));
      // Block ends above the variable count are ignored.
      script.push_back(csr_row(moke_pkg::CSR_VAR_COUNT, 64'd5));
      script.push_back(csr_row(moke_pkg::CSR_ORDER_MODE, 64'(moke_pkg::MODE_PRODUCT)));
      script.push_back(csr_row(moke_pkg::CSR_BLOCK_ENDS, 64'hA5));
      script.push_back(item_row(EXP_FULL));
      script.push_back(csr_row(moke_pkg::CSR_BLOCK_ENDS, 64'h00));
      script.push_back(item_row(EXP_RAMP));
      script.push_back(csr_row(moke_pkg::CSR_ORDER_MODE, 64'(moke_pkg::MODE_ELIM)));
      script.push_back(csr_row(moke_pkg::CSR_ELIM_COUNT, 64'd0));
      script.push_back(item_row(EXP_RAMP));
      script.push_back(csr_row(moke_pkg::CSR_ELIM_COUNT, 64'd2));
      script.push_back(item_row(EXP_FULL));
      script.push_back(csr_row(moke_pkg::CSR_ELIM_COUNT, 64'd5));
      script.push_back(item_row(EXP_RAMP));
      script.push_back(csr_row(moke_pkg::CSR_VAR_COUNT, 64'd8));
      script.push_back(csr_row(moke_pkg::CSR_ELIM_COUNT, 64'd7));
      script.push_back(item_row(EXP_FULL));
      script.push_back(csr_row(moke_pkg::CSR_ELIM_COUNT, 64'd1));
      script.push_back(item_row(EXP_RAMP));
      script.push_back(csr_row(moke_pkg::CSR_DEGREE_VECTOR, 64'd0));
      script.push_back(csr_row(moke_pkg::CSR_VAR_COUNT, 64'd1));
      script.push_back(item_row(EXP_FULL));
      script.push_back(csr_row(moke_pkg::CSR_DEGREE_VECTOR, 64'h00FF_0102_0304_05FF));
      script.push_back(csr_row(moke_pkg::CSR_VAR_COUNT, 64'd8));
      script.push_back(csr_row(moke_pkg::CSR_ORDER_MODE, 64'(moke_pkg::MODE_GRLEX)));
      script.push_back(item_row(EXP_FULL));
      script.push_back(item_row(EXP_MIXED));
      script.push_back(item_row(EXP_ZERO));
   endtask

   always @(posedge clock) begin
      key_result_type want;
      int          i;
      if (!reset && rsp_valid) begin
         if (expected_keys.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("%0t: result with nothing expected, key_0 %0d", $time, rsp_key_0);
         end else begin
            want = expected_keys.pop_front();
            results_checked++;
            if (rsp_weight_value !== want.weight_value) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("%0t: weight_value expected %0d, got %0d", $time,
                           $signed(want.weight_value), rsp_weight_value);
            end
            for (i = 0; i < 8; i++) begin
               if (observed_keys[i] !== want.key[i]) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS)
                     $display("%0t: key_%0d expected %0d, got %0d", $time, i,
                              $signed(want.key[i]), $signed(observed_keys[i]));
               end
            end
         end
      end
   end

   initial begin
      script_row_type row;
      int          r, phase, gap, idle_pct;
      shadow_write(moke_pkg::CSR_ORDER_MODE, 64'(moke_pkg::ORDER_MODE_RST));
      shadow_write(moke_pkg::CSR_VAR_COUNT, 64'(moke_pkg::VAR_COUNT_RST));
      shadow_write(moke_pkg::CSR_DEGREE_VECTOR, moke_pkg::DEGREE_RST);
      shadow_write(moke_pkg::CSR_BLOCK_ENDS, 64'(moke_pkg::BLOCK_ENDS_RST));
      shadow_write(moke_pkg::CSR_ELIM_COUNT, 64'(moke_pkg::ELIM_COUNT_RST));
      shadow_write(moke_pkg::CSR_WEIGHT_VECTOR, 64'd0);
      shadow_write(moke_pkg::CSR_WEIGHT_ENABLE, 64'd0);
      build_script();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (r = 0; r < script.size(); r++) begin
         row = script[r];
         if (row.is_write) begin
            if (r == 0 || !script[r - 1].is_write) settle();
            write_csr(row.index, row.data);
            if (r + 1 == script.size() || !script[r + 1].is_write) begin
               close_csr();
               settings_used++;
            end
         end else begin
            send_item(row.exps, row.has_key, row.key);
         end
      end

      // Random part: new settings each phase, sender gaps varying by phase.
      for (phase = 0; phase < PHASES; phase++) begin
         settle();
         randomize_settings();
         case (phase % 3)
            0: idle_pct = 0;
            1: idle_pct = 88;
            default: idle_pct = 28;
         endcase
         repeat (ITEMS_PER_PHASE) begin
            send_item(random_exponents(), 1'b0, '0);
            gap = 0;
            while ($urandom_range(99) < idle_pct) gap++;
            if (gap > 0) begin
               start <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end

      settle();
      repeat (END_CYCLES) @(posedge clock);
      $display("Sent %0d exponent vectors under %0d register settings; %0d results checked.",
               items_sent, settings_used, results_checked);
      $display("Ran all order modes, zero and oversized variable counts and sender gaps; %0d mismatches.",
               mismatch_count);
      if (mismatch_count == 0 && expected_keys.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
